/* rtl/vqbfd_pkg.sv */
// Shared types, layout table, command codes and register indexes for the block frame decoder.
// No dependencies.
package vqbfd_pkg;

    localparam logic [1:0] CMD_LOAD_WORD  = 2'd0;
    localparam logic [1:0] CMD_LOAD_COLOR = 2'd1;
    localparam logic [1:0] CMD_DECODE     = 2'd2;
    localparam logic [1:0] CMD_RESTART    = 2'd3;

    localparam logic [1:0] FILL_C0     = 2'd0;
    localparam logic [1:0] FILL_TABLE  = 2'd1;
    localparam logic [1:0] FILL_DIRECT = 2'd2;

    localparam logic [3:0] NUM_LAYOUTS = 4'd10;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_BPR  = 3'd1;
    localparam logic [2:0] REG_ROWS = 3'd2;
    localparam logic [2:0] REG_LW   = 3'd3;
    localparam logic [2:0] REG_BASE = 3'd4;

    typedef struct packed {
        logic [3:0]  count;
        logic [1:0]  cw_shift;
        logic [3:0]  col_step;
        logic [3:0]  row_lines;
        logic        wide;
        logic [1:0]  fill;
        logic        half;
        logic [23:0] line;
        logic [7:0]  xoff;
        logic [23:0] word;
    } layout_t;

    // One decoded block handed from the front to the back.
    typedef struct packed {
        logic [31:0] base;
        logic [14:0] stride;
        logic [15:0] code;
        logic        solid;
        logic [31:0] fillword;
        logic        frame_end;
        logic [3:0]  mode;
    } job_t;

    function automatic layout_t layout_of(input logic [3:0] m);
        layout_t l;
        l = '0;
        case (m)
            4'd0: l = '{4'd8, 2'd3, 4'd8, 4'd4, 1'b1, FILL_TABLE, 1'b0,
                        {3'd3,3'd3,3'd2,3'd2,3'd1,3'd1,3'd0,3'd0}, 8'b10101010,
                        {3'd7,3'd6,3'd5,3'd4,3'd3,3'd2,3'd1,3'd0}};
            4'd1: l = '{4'd4, 2'd3, 4'd8, 4'd4, 1'b1, FILL_TABLE, 1'b0,
                        {12'd0,3'd2,3'd2,3'd0,3'd0}, 8'b00001010,
                        {12'd0,3'd5,3'd4,3'd1,3'd0}};
            4'd2: l = '{4'd2, 2'd1, 4'd4, 4'd2, 1'b0, FILL_C0, 1'b0,
                        {18'd0,3'd1,3'd0}, 8'b0, {18'd0,3'd1,3'd0}};
            4'd3: l = '{4'd4, 2'd2, 4'd4, 4'd4, 1'b0, FILL_C0, 1'b0,
                        {12'd0,3'd3,3'd2,3'd1,3'd0}, 8'b0,
                        {12'd0,3'd3,3'd2,3'd1,3'd0}};
            4'd4: l = '{4'd2, 2'd2, 4'd2, 4'd2, 1'b0, FILL_C0, 1'b1,
                        {18'd0,3'd1,3'd0}, 8'b0, {18'd0,3'd2,3'd0}};
            4'd5: l = '{4'd2, 2'd1, 4'd2, 4'd2, 1'b0, FILL_C0, 1'b1,
                        {18'd0,3'd1,3'd0}, 8'b0, {18'd0,3'd2,3'd0}};
            4'd6: l = '{4'd8, 2'd3, 4'd8, 4'd4, 1'b1, FILL_DIRECT, 1'b0,
                        {3'd3,3'd3,3'd2,3'd2,3'd1,3'd1,3'd0,3'd0}, 8'b10101010,
                        {3'd7,3'd6,3'd5,3'd4,3'd3,3'd2,3'd1,3'd0}};
            4'd7: l = '{4'd4, 2'd2, 4'd8, 4'd2, 1'b1, FILL_DIRECT, 1'b0,
                        {12'd0,3'd1,3'd1,3'd0,3'd0}, 8'b00001010,
                        {12'd0,3'd3,3'd2,3'd1,3'd0}};
            4'd8: l = '{4'd8, 2'd3, 4'd4, 4'd8, 1'b0, FILL_C0, 1'b0,
                        {3'd7,3'd6,3'd5,3'd4,3'd3,3'd2,3'd1,3'd0}, 8'b0,
                        {3'd7,3'd6,3'd5,3'd4,3'd3,3'd2,3'd1,3'd0}};
            4'd9: l = '{4'd8, 2'd3, 4'd8, 4'd4, 1'b0, FILL_C0, 1'b0,
                        {3'd3,3'd3,3'd2,3'd2,3'd1,3'd1,3'd0,3'd0}, 8'b10101010,
                        {3'd7,3'd6,3'd5,3'd4,3'd3,3'd2,3'd1,3'd0}};
            default: l = '0;
        endcase
        return l;
    endfunction

endpackage

/* rtl/vq_block_frame_decoder.sv */
// Block frame decoder top level: front end, job queue and back end.
// A decode passes the front stage register, job queue, read stage and output register.
// Throughput: one write per cycle while out_ready holds; each decode command makes as many
// writes as its layout sets, with one codebook read per write. A codebook load waits until
// every earlier decode has read its codewords.
// Reset clears the cursor and all valid flags and loads the configuration defaults;
// the codebook and color table hold no reset value.
module vq_block_frame_decoder #(
    parameter int CODEBOOK_WORDS = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  code_low,
    input  logic [7:0]  code_high,
    input  logic [15:0] load_addr,
    input  logic [31:0] load_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] write_addr,
    output logic [31:0] write_data,
    output logic [3:0]  byte_enable,
    output logic        last_of_block,
    output logic        frame_done,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CB_AW = $clog2(CODEBOOK_WORDS);

    logic [3:0]  mode_reg;
    logic [10:0] bpr_reg, rows_reg;
    logic [13:0] lw_reg;
    logic [31:0] base_reg;
    logic              cb_we;
    logic [CB_AW-1:0]  cb_waddr;
    logic [31:0]       cb_wdata;
    logic fj_valid, fj_ready, bj_valid, bj_ready;
    vqbfd_pkg::job_t fj, bj;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            bpr_reg  <= 11'd1;
            rows_reg <= 11'd1;
            lw_reg   <= 14'd1;
            base_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vqbfd_pkg::REG_MODE: mode_reg <= cfg_data[3:0];
                vqbfd_pkg::REG_BPR:  bpr_reg  <= cfg_data[10:0];
                vqbfd_pkg::REG_ROWS: rows_reg <= cfg_data[10:0];
                vqbfd_pkg::REG_LW:   lw_reg   <= cfg_data[13:0];
                vqbfd_pkg::REG_BASE: base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    vqbfd_front #(.CB_AW(CB_AW)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .cmd, .code_low, .code_high,
        .load_addr, .load_data,
        .layout_mode(mode_reg), .blocks_per_row(bpr_reg), .num_rows(rows_reg),
        .line_width(lw_reg), .frame_base(base_reg), .jobs_pending(bj_valid),
        .cb_we, .cb_waddr, .cb_wdata,
        .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
    );

    vqbfd_queue u_queue (
        .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
    );

    vqbfd_back #(.CB_AW(CB_AW)) u_back (
        .clk, .rst_n, .cb_we, .cb_waddr, .cb_wdata,
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .out_valid, .out_ready, .write_addr, .write_data, .byte_enable,
        .last_of_block, .frame_done
    );

endmodule

/* rtl/vqbfd_front.sv */
// Front end: takes commands, writes loads to the codebook, looks up colors,
// walks the block cursor and hands decode jobs to the queue. Uses vqbfd_pkg.
module vqbfd_front #(
    parameter int CB_AW = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             cmd,
    input  logic [7:0]             code_low,
    input  logic [7:0]             code_high,
    input  logic [15:0]            load_addr,
    input  logic [31:0]            load_data,
    input  logic [3:0]             layout_mode,
    input  logic [10:0]            blocks_per_row,
    input  logic [10:0]            num_rows,
    input  logic [13:0]            line_width,
    input  logic [31:0]            frame_base,
    input  logic                   jobs_pending,
    output logic                   cb_we,
    output logic [CB_AW-1:0]       cb_waddr,
    output logic [31:0]            cb_wdata,
    output logic                   job_valid,
    input  logic                   job_ready,
    output vqbfd_pkg::job_t        job
);

    logic [15:0] color_mem [32768];
    logic [31:0] row_start_reg, row_start_next;
    logic [15:0] col_off_reg, col_off_next;
    logic [10:0] col_cnt_reg, col_cnt_next;
    logic [10:0] row_cnt_reg, row_cnt_next;
    logic        st_valid_reg;
    vqbfd_pkg::job_t st_job_reg;
    logic [15:0] st_color_reg;

    vqbfd_pkg::layout_t ly;
    logic [15:0] code;
    logic        acc, is_dec;
    logic        stage_free, load_hold;
    logic [14:0] stride;
    logic [18:0] row_bytes;
    logic        fend;

    assign code   = {code_high, code_low};
    assign ly     = vqbfd_pkg::layout_of(layout_mode);
    assign stage_free = !st_valid_reg || job_ready;
    // A codebook load waits until every earlier decode has read its codewords.
    assign load_hold = (cmd == vqbfd_pkg::CMD_LOAD_WORD) && (st_valid_reg || jobs_pending);
    assign in_ready = stage_free && !load_hold;
    assign acc    = in_valid && in_ready;
    assign is_dec = (cmd == vqbfd_pkg::CMD_DECODE) && (layout_mode < vqbfd_pkg::NUM_LAYOUTS);
    assign stride = ly.wide ? {line_width, 1'b0} : {1'b0, line_width};
    assign row_bytes = 19'(stride) * 19'(ly.row_lines);

    assign cb_we    = acc && (cmd == vqbfd_pkg::CMD_LOAD_WORD);
    assign cb_waddr = CB_AW'(load_addr);
    assign cb_wdata = load_data;

    // Cursor update for a decode or a restart.
    always_comb
    begin
        row_start_next = row_start_reg;
        col_off_next   = col_off_reg;
        col_cnt_next   = col_cnt_reg;
        row_cnt_next   = row_cnt_reg;
        fend           = 1'b0;
        if (acc && cmd == vqbfd_pkg::CMD_RESTART)
        begin
            row_start_next = frame_base;
            col_off_next   = '0;
            col_cnt_next   = '0;
            row_cnt_next   = '0;
        end
        else if (acc && is_dec)
        begin
            col_cnt_next = col_cnt_reg + 11'd1;
            col_off_next = col_off_reg + 16'(ly.col_step);
            if (col_cnt_next == blocks_per_row)
            begin
                col_cnt_next   = '0;
                col_off_next   = '0;
                row_start_next = row_start_reg + 32'(row_bytes);
                row_cnt_next   = row_cnt_reg + 11'd1;
                if (row_cnt_next == num_rows)
                begin
                    fend           = 1'b1;
                    row_start_next = frame_base;
                    row_cnt_next   = '0;
                end
            end
        end
    end

    // Cursor registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_start_reg <= '0;
            col_off_reg   <= '0;
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            st_valid_reg  <= 1'b0;
        end
        else
        begin
            row_start_reg <= row_start_next;
            col_off_reg   <= col_off_next;
            col_cnt_reg   <= col_cnt_next;
            row_cnt_reg   <= row_cnt_next;
            if (stage_free)
                st_valid_reg <= acc && is_dec;
        end
    end

    // Color table and the stage register holding the job and its color read.
    always_ff @(posedge clk)
    begin
        if (acc && cmd == vqbfd_pkg::CMD_LOAD_COLOR)
            color_mem[load_addr[14:0]] <= load_data[15:0];
        if (acc && is_dec)
        begin
            st_color_reg       <= color_mem[code[14:0]];
            st_job_reg.base    <= row_start_reg + 32'(col_off_reg);
            st_job_reg.stride  <= stride;
            st_job_reg.code    <= code;
            st_job_reg.solid   <= (ly.fill == vqbfd_pkg::FILL_C0) ? (code[15:8] == 8'hFF)
                                                                  : code[15];
            st_job_reg.fillword <= (ly.fill == vqbfd_pkg::FILL_C0)
                ? (ly.half ? {16'd0, code[7:0], code[7:0]} : {4{code[7:0]}})
                : {1'b0, code[14:0], 1'b0, code[14:0]};
            st_job_reg.frame_end <= fend;
            st_job_reg.mode      <= layout_mode;
        end
    end

    // Table fill takes the color read in the stage.
    always_comb
    begin
        job = st_job_reg;
        if (vqbfd_pkg::layout_of(st_job_reg.mode).fill == vqbfd_pkg::FILL_TABLE)
            job.fillword = {st_color_reg, st_color_reg};
    end
    assign job_valid = st_valid_reg;

endmodule

/* rtl/vqbfd_queue.sv */
// Two-entry job queue between the front and back ends. Uses vqbfd_pkg.
module vqbfd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  vqbfd_pkg::job_t wr_job,
    output logic            rd_valid,
    input  logic            rd_ready,
    output vqbfd_pkg::job_t rd_job
);

    vqbfd_pkg::job_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_job   = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_job;
    end

endmodule

/* rtl/vqbfd_back.sv */
// Back end: steps through the writes of one job, reads the codebook once per
// write and drives the registered output. Uses vqbfd_pkg.
module vqbfd_back #(
    parameter int CB_AW = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cb_we,
    input  logic [CB_AW-1:0]   cb_waddr,
    input  logic [31:0]        cb_wdata,
    input  logic               job_valid,
    output logic               job_ready,
    input  vqbfd_pkg::job_t    job,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        write_addr,
    output logic [31:0]        write_data,
    output logic [3:0]         byte_enable,
    output logic               last_of_block,
    output logic               frame_done
);

    logic [31:0] cb_mem [2**CB_AW];
    logic [2:0]  k_reg;
    logic        p_valid_reg, p_solid_reg, p_half_reg, p_last_reg, p_fend_reg;
    logic [31:0] p_addr_reg, p_fill_reg, p_word_reg;
    logic        o_valid_reg;

    vqbfd_pkg::layout_t ly;
    logic        adv, last_k;
    logic [2:0]  ln, wd;
    logic [18:0] cb_full;
    logic [31:0] pdata;

    assign ly     = vqbfd_pkg::layout_of(job.mode);
    assign adv    = !o_valid_reg || out_ready || !p_valid_reg;
    assign last_k = ({1'b0, k_reg} + 4'd1) == ly.count;
    assign job_ready = adv && last_k;
    assign ln     = ly.line[k_reg*3 +: 3];
    assign wd     = ly.word[k_reg*3 +: 3];
    assign cb_full = (19'(job.code) << ly.cw_shift) + 19'(wd);

    // Write index within the block and the stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg       <= '0;
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                p_valid_reg <= job_valid;
                if (job_valid)
                    k_reg <= last_k ? 3'd0 : k_reg + 3'd1;
            end
            if (!o_valid_reg || out_ready)
                o_valid_reg <= p_valid_reg;
        end
    end

    // Codebook memory and read stage.
    always_ff @(posedge clk)
    begin
        if (cb_we)
            cb_mem[cb_waddr] <= cb_wdata;
        if (adv && job_valid)
        begin
            p_word_reg  <= cb_mem[cb_full[CB_AW-1:0]];
            p_addr_reg  <= job.base + 32'(19'(job.stride) * 19'(ln))
                         + 32'({ly.xoff[k_reg], 2'b00});
            p_fill_reg  <= job.fillword;
            p_solid_reg <= job.solid;
            p_half_reg  <= ly.half;
            p_last_reg  <= last_k;
            p_fend_reg  <= last_k && job.frame_end;
        end
    end

    assign pdata = p_solid_reg ? p_fill_reg
                 : (p_half_reg ? {16'd0, p_word_reg[23:16], p_word_reg[7:0]} : p_word_reg);

    // Output register.
    always_ff @(posedge clk)
    begin
        if ((!o_valid_reg || out_ready) && p_valid_reg)
        begin
            write_addr    <= p_addr_reg;
            write_data    <= pdata;
            byte_enable   <= p_half_reg ? 4'd3 : 4'd15;
            last_of_block <= p_last_reg;
            frame_done    <= p_fend_reg;
        end
    end
    assign out_valid = o_valid_reg;

endmodule
